>>> rtl/pis_pkg.sv
// Package for the Poisson inversion sampler: field structs, state codes,
// fixed-point constants, and the exp(-y) and reciprocal ROMs built at elaboration.
// Standalone; used by pis_mac and poisson_inversion_sampler_core.
package pis_pkg;

	localparam int MAX_COUNT      = 255;
	localparam int PROB_FRAC_BITS = 40;

	localparam int U_W           = 16;
	localparam int RATE_W        = 16;
	localparam int RATE_FRAC     = 12;
	localparam int RATE_INT_BITS = RATE_W - RATE_FRAC;
	localparam int HI_BITS       = 6;
	localparam int LO_BITS       = 6;
	localparam int ROM_FRAC      = 62;
	localparam int RECIP_FRAC    = 32;
	localparam int SERIES_TERMS  = 40;

	localparam int OUT_W     = 8;
	localparam int CNT_W     = $clog2(MAX_COUNT + 1);
	localparam int P_W       = PROB_FRAC_BITS + 1;
	localparam int T_W       = P_W + RATE_INT_BITS;
	localparam int EXP_SHIFT = 2 * ROM_FRAC - PROB_FRAC_BITS;
	localparam int U_PAD     = PROB_FRAC_BITS - U_W;
	localparam int ACC_W     = 128;

	localparam logic [63:0] ROM_ONE = 64'd1 << ROM_FRAC;

	typedef struct packed {
		logic [U_W-1:0]    uniform_frac;
		logic [RATE_W-1:0] rate;
	} pis_in_t;

	typedef struct packed {
		logic [OUT_W-1:0] event_count;
		logic             saturated;
	} pis_out_t;

	// one partial product for the shared MAC
	typedef struct packed {
		logic       vld;
		logic       clr;
		logic [1:0] sh;
	} pis_mac_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXP1,
		ST_EXP1_W,
		ST_EXP2,
		ST_EXP2_W,
		ST_INIT,
		ST_MULA,
		ST_MULA_W,
		ST_MULB,
		ST_MULB_W,
		ST_ACC
	} pis_state_t;

	// restoring long division, elaboration use only
	function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [CNT_W-1:0] den);
		logic [63:0]    quo;
		logic [CNT_W:0] rem;
		int             i;
		quo = '0;
		rem = '0;
		for (i = 63; i >= 0; i--) begin
			rem = {rem[CNT_W-1:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic logic [63:0] mul_rom(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return 64'(prod >> ROM_FRAC);
	endfunction

	// exp(-y), y in 2.62 and at most 1.0; alternating series, odd and even sums kept apart
	function automatic logic [63:0] exp_neg(input logic [63:0] y);
		logic [63:0] term;
		logic [63:0] even;
		logic [63:0] odd;
		int          k;
		term = ROM_ONE;
		even = ROM_ONE;
		odd  = '0;
		for (k = 1; k <= SERIES_TERMS; k++) begin
			term = div_u64(mul_rom(term, y), CNT_W'(k));
			if (k % 2 == 1)
				odd = odd + term;
			else
				even = even + term;
		end
		return even - odd;
	endfunction

	function automatic logic [15:0][63:0] build_e_int();
		logic [15:0][63:0] tbl;
		logic [63:0]       e1;
		int                i;
		e1     = exp_neg(ROM_ONE);
		tbl[0] = ROM_ONE;
		for (i = 1; i < 16; i++)
			tbl[i] = mul_rom(tbl[i-1], e1);
		return tbl;
	endfunction

	function automatic logic [63:0][63:0] build_e_frac(input int shift);
		logic [63:0][63:0] tbl;
		int                i;
		for (i = 0; i < 64; i++)
			tbl[i] = exp_neg(64'(i) << shift);
		return tbl;
	endfunction

	function automatic logic [MAX_COUNT:0][31:0] build_recip();
		logic [MAX_COUNT:0][31:0] tbl;
		int                       i;
		tbl[0] = '0;
		for (i = 1; i <= MAX_COUNT; i++)
			tbl[i] = 32'(div_u64(64'd1 << RECIP_FRAC, CNT_W'(i)));
		return tbl;
	endfunction

	localparam logic [15:0][63:0]        E_INT_ROM = build_e_int();
	localparam logic [63:0][63:0]        E_HI_ROM  = build_e_frac(ROM_FRAC - HI_BITS);
	localparam logic [63:0][63:0]        E_LO_ROM  = build_e_frac(ROM_FRAC - HI_BITS - LO_BITS);
	// entry 1 (2^32) does not fit; the sequencer skips that multiply
	localparam logic [MAX_COUNT:0][31:0] RECIP_ROM = build_recip();

endpackage

>>> rtl/pis_mac.sv
// Shared 32x32 multiply-accumulate unit with a 128-bit accumulator.
// Product is registered, then added at a 0/32/64-bit offset. Uses pis_pkg.
module pis_mac (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pis_pkg::pis_mac_ctl_t     ctl,
	input  logic [31:0]               a,
	input  logic [31:0]               b,
	output logic [pis_pkg::ACC_W-1:0] acc
);

	pis_pkg::pis_mac_ctl_t     ctl_s1;
	logic [63:0]               prod_s1;
	logic [pis_pkg::ACC_W-1:0] acc_q;
	logic [pis_pkg::ACC_W-1:0] addend;
	logic [pis_pkg::ACC_W-1:0] base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		if (ctl_s1.vld)
			acc_q <= base + addend;
	end

	always_comb begin
		case (ctl_s1.sh)
			2'd1:    addend = pis_pkg::ACC_W'(prod_s1) << 32;
			2'd2:    addend = pis_pkg::ACC_W'(prod_s1) << 64;
			default: addend = pis_pkg::ACC_W'(prod_s1);
		endcase
		base = ctl_s1.clr ? '0 : acc_q;
	end

	assign acc = acc_q;

endmodule

>>> rtl/poisson_inversion_sampler_core.sv
// Top level of the Poisson inversion sampler: sequencer and datapath
// around one shared pis_mac. Uses pis_pkg for types, ROMs and constants.
//
// channel  dir  handshake                 payload
// command  in   start & !busy             cmd    (uniform_frac, rate)
// result   out  done, one-cycle strobe    result (event_count, saturated)
//
// Every product goes through the single 32x32 MAC, one partial per cycle in
// the issuing states. exp(-lam) takes two 4-partial products (EXP1, EXP1_W,
// EXP2, EXP2_W), then INIT; each further count runs MULA, MULA_W, MULB,
// MULB_W and ACC (the first skips MULB). busy stays high for the whole search.
// Reset (arst_n low) returns the sequencer to idle; no result is then pending.
// The receiver cannot stall: done is high for exactly one cycle.
module poisson_inversion_sampler_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  pis_pkg::pis_in_t   cmd,
	output logic               busy,
	output logic               done,
	output pis_pkg::pis_out_t  result
);

	pis_pkg::pis_state_t            state_q, state_d;
	logic [1:0]                     cnt_q;
	logic [pis_pkg::U_W-1:0]        u_q;
	logic [pis_pkg::RATE_W-1:0]     lam_q;
	logic [63:0]                    q_q;
	logic [pis_pkg::P_W-1:0]        p_q, s_q;
	logic [pis_pkg::CNT_W-1:0]      x_q;
	logic                           done_q;
	pis_pkg::pis_out_t              result_q;

	logic [pis_pkg::ACC_W-1:0]      acc;
	pis_pkg::pis_mac_ctl_t          mac_ctl;
	logic [63:0]                    opa, opb, q_acc;
	logic [31:0]                    a_chunk, b_chunk;
	logic [pis_pkg::T_W-1:0]        t_acc;
	logic                           accept, issue, last, decide, init;
	logic [pis_pkg::P_W-1:0]        p_new, s_new, u_cmp;
	logic                           more, cont;

	assign accept = start && (state_q == pis_pkg::ST_IDLE);
	assign busy   = (state_q != pis_pkg::ST_IDLE);
	assign q_acc  = 64'(acc >> pis_pkg::ROM_FRAC);
	assign t_acc  = pis_pkg::T_W'(acc >> pis_pkg::RATE_FRAC);
	assign u_cmp  = pis_pkg::P_W'(u_q) << pis_pkg::U_PAD;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pis_pkg::ST_IDLE:   if (start) state_d = pis_pkg::ST_EXP1;
			pis_pkg::ST_EXP1:   if (cnt_q == 2'd3) state_d = pis_pkg::ST_EXP1_W;
			pis_pkg::ST_EXP1_W: state_d = pis_pkg::ST_EXP2;
			pis_pkg::ST_EXP2:   if (cnt_q == 2'd3) state_d = pis_pkg::ST_EXP2_W;
			pis_pkg::ST_EXP2_W: state_d = pis_pkg::ST_INIT;
			pis_pkg::ST_INIT,
			pis_pkg::ST_ACC:    state_d = cont ? pis_pkg::ST_MULA : pis_pkg::ST_IDLE;
			pis_pkg::ST_MULA:   if (cnt_q == 2'd1) state_d = pis_pkg::ST_MULA_W;
			// 1/1 is not in the ROM; t is already the new p
			pis_pkg::ST_MULA_W: state_d = (x_q == pis_pkg::CNT_W'(1)) ?
			                              pis_pkg::ST_ACC : pis_pkg::ST_MULB;
			pis_pkg::ST_MULB:   if (cnt_q == 2'd1) state_d = pis_pkg::ST_MULB_W;
			pis_pkg::ST_MULB_W: state_d = pis_pkg::ST_ACC;
			default:            state_d = pis_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: MAC operands and control
	always_comb begin
		issue  = 1'b0;
		last   = 1'b0;
		decide = 1'b0;
		init   = 1'b0;
		opa    = '0;
		opb    = '0;
		case (state_q)
			pis_pkg::ST_EXP1: begin
				issue = 1'b1;
				last  = (cnt_q == 2'd3);
				opa   = pis_pkg::E_INT_ROM[lam_q[15:12]];
				opb   = pis_pkg::E_HI_ROM[lam_q[11:6]];
			end
			pis_pkg::ST_EXP2: begin
				issue = 1'b1;
				last  = (cnt_q == 2'd3);
				opa   = (cnt_q == 2'd0) ? q_acc : q_q;
				opb   = pis_pkg::E_LO_ROM[lam_q[5:0]];
			end
			pis_pkg::ST_MULA: begin
				issue = 1'b1;
				last  = (cnt_q == 2'd1);
				opa   = 64'(p_q);
				opb   = 64'(lam_q);
			end
			pis_pkg::ST_MULB: begin
				// acc still holds t: it is cleared only after the second issue
				issue = 1'b1;
				last  = (cnt_q == 2'd1);
				opa   = 64'(t_acc);
				opb   = 64'(pis_pkg::RECIP_ROM[x_q]);
			end
			pis_pkg::ST_INIT: begin
				decide = 1'b1;
				init   = 1'b1;
			end
			pis_pkg::ST_ACC: begin
				decide = 1'b1;
			end
			default: begin
				issue = 1'b0;
			end
		endcase
		a_chunk     = cnt_q[0] ? opa[63:32] : opa[31:0];
		b_chunk     = cnt_q[1] ? opb[63:32] : opb[31:0];
		mac_ctl.vld = issue;
		mac_ctl.clr = (cnt_q == 2'd0);
		mac_ctl.sh  = {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
	end

	// new term, running sum and loop test
	always_comb begin
		if (init)
			p_new = pis_pkg::P_W'(acc >> pis_pkg::EXP_SHIFT);
		else if (x_q == pis_pkg::CNT_W'(1))
			p_new = pis_pkg::P_W'(acc >> pis_pkg::RATE_FRAC);
		else
			p_new = pis_pkg::P_W'(acc >> pis_pkg::RECIP_FRAC);
		s_new = init ? p_new : (s_q + p_new);
		more  = (u_cmp > s_new);
		cont  = more && (x_q < pis_pkg::CNT_W'(pis_pkg::MAX_COUNT));
	end

	pis_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (a_chunk),
		.b      (b_chunk),
		.acc    (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pis_pkg::ST_IDLE;
			cnt_q   <= '0;
			x_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (issue && !last) ? cnt_q + 2'd1 : 2'd0;
			done_q  <= decide && !cont;
			if (accept)
				x_q <= '0;
			else if (decide && cont)
				x_q <= x_q + pis_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			u_q   <= cmd.uniform_frac;
			lam_q <= cmd.rate;
		end
		if (state_q == pis_pkg::ST_EXP2 && cnt_q == 2'd0)
			q_q <= q_acc;
		if (decide) begin
			p_q <= p_new;
			s_q <= s_new;
		end
		if (decide && !cont) begin
			result_q.event_count <= pis_pkg::OUT_W'(x_q);
			result_q.saturated   <= more;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transfer accepted but block not busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result presented while search still running");

	a_sat_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.saturated) |->
			(result.event_count == pis_pkg::OUT_W'(pis_pkg::MAX_COUNT)))
		else $error("saturated result below count limit");

	a_mac_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !mac_ctl.vld)
		else $error("MAC issued while idle");

endmodule
